// ===== src/e2q_pkg.sv =====
`timescale 1ns / 1ps

package e2q_pkg;

  // Angle codes and quaternion components share one width.
  localparam int AngleW = 16;
  localparam int QuatW  = 16;

  // Q30 data path: values stay within about plus or minus 4.
  localparam int DataW = 34;

  // Default and largest CORDIC iteration count.
  localparam int CordicStagesDef = 14;
  localparam int AtanEntries     = 24;

  localparam logic signed [DataW-1:0] Q30Pi      = 34'sd3373259426;
  localparam logic signed [DataW-1:0] Q30HalfPi  = 34'sd1686629713;
  localparam logic signed [DataW-1:0] Q30InvGain = 34'sd652032874;
  localparam logic signed [DataW-1:0] Q14One     = 34'sd16384;

  // Arctangent of 2^-i in Q30, truncated.
  function automatic logic signed [DataW-1:0] atan_q30(input int i);
    logic signed [DataW-1:0] v;
    begin
      case (i)
        0:  v = 34'sh03243F6A8;
        1:  v = 34'sh01DAC6705;
        2:  v = 34'sh00FADBAFC;
        3:  v = 34'sh007F56EA6;
        4:  v = 34'sh003FEAB76;
        5:  v = 34'sh001FFD55B;
        6:  v = 34'sh000FFFAAA;
        7:  v = 34'sh0007FFF55;
        8:  v = 34'sh0003FFFEA;
        9:  v = 34'sh0001FFFFD;
        10: v = 34'sh0000FFFFF;
        11: v = 34'sh00007FFFF;
        12: v = 34'sh00003FFFF;
        13: v = 34'sh00001FFFF;
        14: v = 34'sh00000FFFF;
        15: v = 34'sh000007FFF;
        16: v = 34'sh000003FFF;
        17: v = 34'sh000001FFF;
        18: v = 34'sh000000FFF;
        19: v = 34'sh0000007FF;
        20: v = 34'sh0000003FF;
        21: v = 34'sh0000001FF;
        22: v = 34'sh0000000FF;
        default: v = 34'sh00000007F;
      endcase
      return v;
    end
  endfunction

  // Cosine and sine of one half angle in Q30.
  typedef struct packed {
    logic signed [DataW-1:0] c;
    logic signed [DataW-1:0] s;
  } cs_t;

endpackage

// ===== src/euler_to_quaternion_core.sv =====
`timescale 1ns / 1ps

// Euler angles (roll, pitch, yaw, radians, signed Q4.12) to the unit
// quaternion w, x, y, z (signed Q1.14, ZYX order, saturated to plus or minus
// one). The block accepts one beat per clock while the output is not stalled,
// and is fully pipelined, with CORDIC_STAGES + 5 register stages: range
// reduction, one stage per CORDIC iteration (capped at the arctangent table
// size), two product stages, the sum, and the output register, which takes the
// floored and saturated result. Backpressure on the output stalls the whole
// pipeline; nothing is lost or repeated.
module euler_to_quaternion_core #(
  parameter int CORDIC_STAGES = e2q_pkg::CordicStagesDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // roll_angle, pitch_angle, yaw_angle
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata   // quat_w, quat_x, quat_y, quat_z
);

  localparam int DW = e2q_pkg::DataW;
  localparam int NS = (CORDIC_STAGES < e2q_pkg::AtanEntries) ?
                      CORDIC_STAGES : e2q_pkg::AtanEntries;
  // Register stages ahead of the output register: CORDIC, two products, sum.
  localparam int LAT = NS + 4;

  logic            en;
  logic [LAT-1:0]  vld_r;
  e2q_pkg::cs_t    cs_r, cs_p, cs_y;

  // The pipeline advances whenever the output stage can take a beat.
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_tvalid};
    end
  end

  e2q_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_roll (
    .clk(clk), .en(en), .angle(in_tdata[15:0]), .cs(cs_r));
  e2q_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_pitch (
    .clk(clk), .en(en), .angle(in_tdata[31:16]), .cs(cs_p));
  e2q_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_yaw (
    .clk(clk), .en(en), .angle(in_tdata[47:32]), .cs(cs_y));

  // First products: yaw term times roll term, floored to Q30.
  logic signed [DW-1:0] cycr_r, cysr_r, sysr_r, sycr_r, cp_r, sp_r;
  logic signed [2*DW-1:0] m_cycr, m_cysr, m_sysr, m_sycr;

  always_comb begin
    m_cycr = (2*DW)'(cs_y.c) * (2*DW)'(cs_r.c);
    m_cysr = (2*DW)'(cs_y.c) * (2*DW)'(cs_r.s);
    m_sysr = (2*DW)'(cs_y.s) * (2*DW)'(cs_r.s);
    m_sycr = (2*DW)'(cs_y.s) * (2*DW)'(cs_r.c);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cycr_r <= DW'(m_cycr >>> 30);
      cysr_r <= DW'(m_cysr >>> 30);
      sysr_r <= DW'(m_sysr >>> 30);
      sycr_r <= DW'(m_sycr >>> 30);
      cp_r   <= cs_p.c;
      sp_r   <= cs_p.s;
    end
  end

  // Second products with the pitch terms.
  logic signed [DW-1:0] p_r [8];
  logic signed [2*DW-1:0] m [8];

  always_comb begin
    m[0] = (2*DW)'(cycr_r) * (2*DW)'(cp_r);
    m[1] = (2*DW)'(sysr_r) * (2*DW)'(sp_r);
    m[2] = (2*DW)'(cysr_r) * (2*DW)'(cp_r);
    m[3] = (2*DW)'(sycr_r) * (2*DW)'(sp_r);
    m[4] = (2*DW)'(cycr_r) * (2*DW)'(sp_r);
    m[5] = (2*DW)'(sysr_r) * (2*DW)'(cp_r);
    m[6] = (2*DW)'(sycr_r) * (2*DW)'(cp_r);
    m[7] = (2*DW)'(cysr_r) * (2*DW)'(sp_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 8; k++) begin
        p_r[k] <= DW'(m[k] >>> 30);
      end
    end
  end

  // Component sums with the rounding offset folded in.
  logic signed [DW:0] s_r [4];

  always_ff @(posedge clk) begin
    if (en) begin
      s_r[0] <= (DW+1)'(p_r[0]) + (DW+1)'(p_r[1]) + (DW+1)'(32768);
      s_r[1] <= (DW+1)'(p_r[2]) - (DW+1)'(p_r[3]) + (DW+1)'(32768);
      s_r[2] <= (DW+1)'(p_r[4]) + (DW+1)'(p_r[5]) + (DW+1)'(32768);
      s_r[3] <= (DW+1)'(p_r[6]) - (DW+1)'(p_r[7]) + (DW+1)'(32768);
    end
  end

  // Floor to Q14 and saturate to plus or minus one.
  logic signed [DW:0] q [4];
  logic [63:0] out_nxt;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      q[k] = s_r[k] >>> 16;
      if (q[k] > (DW+1)'(e2q_pkg::Q14One)) begin
        q[k] = (DW+1)'(e2q_pkg::Q14One);
      end else if (q[k] < -(DW+1)'(e2q_pkg::Q14One)) begin
        q[k] = -(DW+1)'(e2q_pkg::Q14One);
      end
      out_nxt[16*k +: 16] = q[k][15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid <= 1'b0;
    end else if (en) begin
      out_tvalid <= vld_r[LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_tdata <= out_nxt;
    end
  end

endmodule

// ===== src/e2q_cordic.sv =====
`timescale 1ns / 1ps

// Pipelined rotation-mode CORDIC: one iteration per register stage.
// Gives the cosine and sine of half the Q4.12 angle code, in Q30.
module e2q_cordic #(
  parameter int CORDIC_STAGES = e2q_pkg::CordicStagesDef
) (
  input  logic                               clk,
  input  logic                               en,
  input  logic signed [e2q_pkg::AngleW-1:0]  angle,
  output e2q_pkg::cs_t                       cs
);

  localparam int DW = e2q_pkg::DataW;
  localparam int NS = (CORDIC_STAGES < e2q_pkg::AtanEntries) ?
                      CORDIC_STAGES : e2q_pkg::AtanEntries;

  logic signed [DW-1:0] x_r [NS+1];
  logic signed [DW-1:0] y_r [NS+1];
  logic signed [DW-1:0] z_r [NS+1];
  logic                 flip_r [NS+1];
  logic signed [DW-1:0] z0;
  logic signed [DW-1:0] z_red;
  logic                 flip_nxt;

  // Half angle in Q30 and range reduction into plus or minus pi/2.
  always_comb begin
    z0 = DW'(angle) <<< 17;
    z_red = z0;
    flip_nxt = 1'b0;
    if (z0 > e2q_pkg::Q30HalfPi) begin
      z_red = z0 - e2q_pkg::Q30Pi;
      flip_nxt = 1'b1;
    end else if (z0 < -e2q_pkg::Q30HalfPi) begin
      z_red = z0 + e2q_pkg::Q30Pi;
      flip_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]    <= e2q_pkg::Q30InvGain;
      y_r[0]    <= '0;
      z_r[0]    <= z_red;
      flip_r[0] <= flip_nxt;
    end
  end

  // One micro-rotation per stage.
  for (genvar i = 0; i < NS; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (en) begin
        flip_r[i+1] <= flip_r[i];
        if (!z_r[i][DW-1]) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - e2q_pkg::atan_q30(i);
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + e2q_pkg::atan_q30(i);
        end
      end
    end
  end

  assign cs.c = flip_r[NS] ? -x_r[NS] : x_r[NS];
  assign cs.s = flip_r[NS] ? -y_r[NS] : y_r[NS];

endmodule
